// File: sv/sorm_pkg.sv
package sorm_pkg;

   // field widths of the transaction payload
   localparam int VALUE_W = 14;
   localparam int INDEX_W = 31;

   // default configuration of the core
   localparam int MODULUS_DEF    = 10000;
   localparam int INDEX_BITS_DEF = 31;

   // multiply-add operations of the shared modular unit, named by destination
   typedef enum logic [3:0] {
      OP_RED_A0,
      OP_RED_A1,
      OP_RED_P,
      OP_RED_Q,
      OP_ACC0,
      OP_ACC1,
      OP_SQ00,
      OP_SQ01,
      OP_SQ10,
      OP_SQ11,
      OP_FINAL
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic   load;
      logic   k_zero;
      logic   issue;
      op_type op;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pipe_busy;
      logic rsp_busy;
   } status_type;

endpackage

// File: sv/second_order_recurrence_mod_power_core.sv
// sequence: a request is accepted, the seeds and coefficients are reduced, then one
//   square-and-multiply step runs per bit of k-1 (none for k below two), then the final step
// concurrency: one transaction at a time; each exponent bit is up to six issues (four when
//   the bit is clear) and a drain of the shared five-stage modular multiply-add unit, and a
//   result still stalled in the output register holds off the next final step
// reset: synchronous, clears the sequencer, the pipeline valids and the output valid
module second_order_recurrence_mod_power_core
   import sorm_pkg::*;
#(
   parameter int MODULUS    = MODULUS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_seed_first,
   input  logic [VALUE_W-1:0] req_seed_second,
   input  logic [VALUE_W-1:0] req_coef_p,
   input  logic [VALUE_W-1:0] req_coef_q,
   input  logic [INDEX_W-1:0] req_term_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_term_value
);

   cmd_type    cmd;
   status_type status;

   sorm_ctrl #(
      .INDEX_BITS (INDEX_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_term_index (req_term_index),
      .req_stall      (req_stall),
      .status         (status),
      .cmd            (cmd)
   );

   sorm_dpath #(
      .MODULUS (MODULUS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .seed_first     (req_seed_first),
      .seed_second    (req_seed_second),
      .coef_p         (req_coef_p),
      .coef_q         (req_coef_q),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_term_value (rsp_term_value)
   );

   // the final multiply-add only starts with the output register free
   assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && cmd.op == OP_FINAL) |-> !rsp_valid)
      else $error("final term issued while output register is occupied");

   // a new transaction never loads over work still in the pipeline
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !status.pipe_busy)
      else $error("operands loaded while multiply-add pipeline is busy");

   // every delivered term is a residue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_term_value) < 32'(MODULUS)))
      else $error("result term is not reduced below the modulus");

endmodule

// File: sv/sorm_dot.sv
module sorm_dot
   import sorm_pkg::*;
#(
   parameter int MODULUS = MODULUS_DEF,
   localparam int RES_W = $clog2(MODULUS),
   localparam int OPW = (RES_W > VALUE_W) ? RES_W : VALUE_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  op_type           in_tag,
   input  logic [OPW-1:0]   in_a,
   input  logic [OPW-1:0]   in_b,
   input  logic [OPW-1:0]   in_c,
   input  logic [OPW-1:0]   in_d,
   output logic             out_valid,
   output op_type           out_tag,
   output logic [RES_W-1:0] out_value,
   output logic             busy
);

   // widths of the five stages
   localparam int PW   = 2 * OPW;
   localparam int X_W  = PW + 1;
   localparam int RW   = X_W - RES_W + 1;
   localparam int RS_W = RES_W + 1;
   localparam int PRW  = X_W + RW;
   localparam int QMW  = RW + RS_W;
   localparam int NSTG = 5;

   // reciprocal for the quotient estimate, which is low by at most one
   localparam logic [RW-1:0]   BAR_R = RW'((64'd1 << X_W) / 64'(MODULUS));
   localparam logic [RS_W-1:0] MOD_C = RS_W'(MODULUS);

   logic [NSTG-1:0]  vld_ff, vld_in;
   op_type           tag_ff [NSTG];
   op_type           tag_in [NSTG];

   logic [PW-1:0]    p0_ff, p0_in, p1_ff, p1_in;
   logic [X_W-1:0]   x_ff, x_in;
   logic [PRW-1:0]   est_full;
   logic [RW-1:0]    qe_ff, qe_in;
   logic [RS_W-1:0]  x3_ff, x3_in;
   logic [QMW-1:0]   qm_full;
   logic [RS_W-1:0]  qm_ff, qm_in;
   logic [RS_W-1:0]  x4_ff, x4_in;
   logic [RS_W-1:0]  rem, rem_sub;
   logic [RES_W-1:0] res_ff, res_in;

   // valid and tag travel alongside the data
   always_comb begin
      vld_in    = {vld_ff[NSTG-2:0], in_valid};
      tag_in[0] = in_tag;
      for (int i = 1; i < NSTG; i++) begin
         tag_in[i] = tag_ff[i-1];
      end
   end

   // stage 1: two products
   assign p0_in = PW'(in_a) * PW'(in_b);
   assign p1_in = PW'(in_c) * PW'(in_d);

   // stage 2: sum of products
   assign x_in = X_W'(p0_ff) + X_W'(p1_ff);

   // stage 3: quotient estimate
   assign est_full = PRW'(x_ff) * PRW'(BAR_R);
   assign qe_in    = est_full[X_W +: RW];
   assign x3_in    = x_ff[RS_W-1:0];

   // stage 4: estimate times modulus, low bits only
   assign qm_full = QMW'(qe_ff) * QMW'(MOD_C);
   assign qm_in   = qm_full[RS_W-1:0];
   assign x4_in   = x3_ff;

   // stage 5: remainder below twice the modulus, one correction
   assign rem     = x4_ff - qm_ff;
   assign rem_sub = rem - MOD_C;
   assign res_in  = (rem >= MOD_C) ? rem_sub[RES_W-1:0] : rem[RES_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      x_ff   <= x_in;
      qe_ff  <= qe_in;
      x3_ff  <= x3_in;
      qm_ff  <= qm_in;
      x4_ff  <= x4_in;
      res_ff <= res_in;
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_tag   = tag_ff[NSTG-1];
   assign out_value = res_ff;
   assign busy      = |vld_ff;

endmodule

// File: sv/sorm_dpath.sv
module sorm_dpath
   import sorm_pkg::*;
#(
   parameter int MODULUS = MODULUS_DEF,
   localparam int RES_W = $clog2(MODULUS),
   localparam int OPW = (RES_W > VALUE_W) ? RES_W : VALUE_W
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [VALUE_W-1:0] seed_first,
   input  logic [VALUE_W-1:0] seed_second,
   input  logic [VALUE_W-1:0] coef_p,
   input  logic [VALUE_W-1:0] coef_q,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [VALUE_W-1:0] rsp_term_value
);

   localparam logic [RES_W-1:0] ONE_R  = RES_W'(1);
   localparam logic [OPW-1:0]   ONE_OP = OPW'(1);

   // raw operands of the transaction
   logic [VALUE_W-1:0] raw_a0_ff, raw_a0_in, raw_a1_ff, raw_a1_in;
   logic [VALUE_W-1:0] raw_p_ff, raw_p_in, raw_q_ff, raw_q_in;

   // reduced seeds, base matrix and top row of the power
   logic [RES_W-1:0] a0_ff, a0_in, a1_ff, a1_in;
   logic [RES_W-1:0] b00_ff, b00_in, b01_ff, b01_in;
   logic [RES_W-1:0] b10_ff, b10_in, b11_ff, b11_in;
   logic [RES_W-1:0] m00_ff, m00_in, m01_ff, m01_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic [OPW-1:0]   op_a, op_b, op_c, op_d;
   logic             dot_valid;
   op_type           dot_tag;
   logic [RES_W-1:0] dot_value;
   logic             dot_busy;
   logic [OPW-1:0]   dot_wide;

   // operand selection for the multiply-add unit
   always_comb begin
      op_a = '0;
      op_b = '0;
      op_c = '0;
      op_d = '0;
      unique case (cmd.op)
         OP_RED_A0: begin
            op_a = OPW'(raw_a0_ff);
            op_b = ONE_OP;
         end
         OP_RED_A1: begin
            op_a = OPW'(raw_a1_ff);
            op_b = ONE_OP;
         end
         OP_RED_P: begin
            op_a = OPW'(raw_p_ff);
            op_b = ONE_OP;
         end
         OP_RED_Q: begin
            op_a = OPW'(raw_q_ff);
            op_b = ONE_OP;
         end
         OP_ACC0: begin
            op_a = OPW'(m00_ff);
            op_b = OPW'(b00_ff);
            op_c = OPW'(m01_ff);
            op_d = OPW'(b10_ff);
         end
         OP_ACC1: begin
            op_a = OPW'(m00_ff);
            op_b = OPW'(b01_ff);
            op_c = OPW'(m01_ff);
            op_d = OPW'(b11_ff);
         end
         OP_SQ00: begin
            op_a = OPW'(b00_ff);
            op_b = OPW'(b00_ff);
            op_c = OPW'(b01_ff);
            op_d = OPW'(b10_ff);
         end
         OP_SQ01: begin
            op_a = OPW'(b00_ff);
            op_b = OPW'(b01_ff);
            op_c = OPW'(b01_ff);
            op_d = OPW'(b11_ff);
         end
         OP_SQ10: begin
            op_a = OPW'(b10_ff);
            op_b = OPW'(b00_ff);
            op_c = OPW'(b11_ff);
            op_d = OPW'(b10_ff);
         end
         OP_SQ11: begin
            op_a = OPW'(b10_ff);
            op_b = OPW'(b01_ff);
            op_c = OPW'(b11_ff);
            op_d = OPW'(b11_ff);
         end
         OP_FINAL: begin
            op_a = OPW'(m00_ff);
            op_b = OPW'(a1_ff);
            op_c = OPW'(m01_ff);
            op_d = OPW'(a0_ff);
         end
         default: begin
         end
      endcase
   end

   sorm_dot #(
      .MODULUS (MODULUS)
   ) u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmd.issue),
      .in_tag    (cmd.op),
      .in_a      (op_a),
      .in_b      (op_b),
      .in_c      (op_c),
      .in_d      (op_d),
      .out_valid (dot_valid),
      .out_tag   (dot_tag),
      .out_value (dot_value),
      .busy      (dot_busy)
   );

   assign dot_wide = OPW'(dot_value);

   // operand load on a new transaction, write-back from the unit otherwise
   always_comb begin
      raw_a0_in = raw_a0_ff;
      raw_a1_in = raw_a1_ff;
      raw_p_in  = raw_p_ff;
      raw_q_in  = raw_q_ff;
      a0_in     = a0_ff;
      a1_in     = a1_ff;
      b00_in    = b00_ff;
      b01_in    = b01_ff;
      b10_in    = b10_ff;
      b11_in    = b11_ff;
      m00_in    = m00_ff;
      m01_in    = m01_ff;
      if (cmd.load) begin
         raw_a0_in = seed_first;
         raw_a1_in = seed_second;
         raw_p_in  = coef_p;
         raw_q_in  = coef_q;
         b10_in    = ONE_R;
         b11_in    = '0;
         // index zero selects the first seed through a swapped top row
         m00_in    = cmd.k_zero ? '0 : ONE_R;
         m01_in    = cmd.k_zero ? ONE_R : '0;
      end else if (dot_valid) begin
         unique case (dot_tag)
            OP_RED_A0: a0_in  = dot_value;
            OP_RED_A1: a1_in  = dot_value;
            OP_RED_P:  b00_in = dot_value;
            OP_RED_Q:  b01_in = dot_value;
            OP_ACC0:   m00_in = dot_value;
            OP_ACC1:   m01_in = dot_value;
            OP_SQ00:   b00_in = dot_value;
            OP_SQ01:   b01_in = dot_value;
            OP_SQ10:   b10_in = dot_value;
            OP_SQ11:   b11_in = dot_value;
            OP_FINAL: begin
            end
            default: begin
            end
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (dot_valid && dot_tag == OP_FINAL) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = dot_wide[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_a0_ff    <= raw_a0_in;
      raw_a1_ff    <= raw_a1_in;
      raw_p_ff     <= raw_p_in;
      raw_q_ff     <= raw_q_in;
      a0_ff        <= a0_in;
      a1_ff        <= a1_in;
      b00_ff       <= b00_in;
      b01_ff       <= b01_in;
      b10_ff       <= b10_in;
      b11_ff       <= b11_in;
      m00_ff       <= m00_in;
      m01_ff       <= m01_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign status.pipe_busy = dot_busy;
   assign status.rsp_busy  = rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_term_value   = rsp_value_ff;

endmodule

// File: sv/sorm_ctrl.sv
module sorm_ctrl
   import sorm_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [INDEX_W-1:0] req_term_index,
   output logic               req_stall,
   input  status_type         status,
   output cmd_type            cmd
);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_SEED      = 7'b0000010,
      ST_SEED_WAIT = 7'b0000100,
      ST_BIT       = 7'b0001000,
      ST_BIT_WAIT  = 7'b0010000,
      ST_FIN       = 7'b0100000,
      ST_FIN_WAIT  = 7'b1000000
   } state_type;

   localparam logic [2:0] STEP_SEED_LAST = 3'd3;
   localparam logic [2:0] STEP_BIT_LAST  = 3'd5;
   localparam logic [2:0] STEP_ACC0      = 3'd0;
   localparam logic [2:0] STEP_ACC1      = 3'd1;
   localparam logic [2:0] STEP_SQ00      = 3'd2;
   localparam logic [2:0] STEP_SQ01      = 3'd3;
   localparam logic [2:0] STEP_SQ10      = 3'd4;
   localparam logic [2:0] STEP_SQ11      = 3'd5;

   state_type             state_ff, state_in;
   logic [2:0]            step_ff, step_in;
   logic [INDEX_BITS-1:0] exp_ff, exp_in;

   logic [31:0]           idx_wide;
   logic [INDEX_BITS-1:0] idx_k;
   logic                  k_zero;
   logic [INDEX_BITS-1:0] exp_shift;
   op_type                seed_op, bit_op;

   // exponent of the companion matrix is k-1, none for k below two
   assign idx_wide  = 32'(req_term_index);
   assign idx_k     = idx_wide[INDEX_BITS-1:0];
   assign k_zero    = (idx_k == '0);
   assign exp_shift = exp_ff >> 1;

   always_comb begin
      unique case (step_ff)
         3'd0:    seed_op = OP_RED_A0;
         3'd1:    seed_op = OP_RED_A1;
         3'd2:    seed_op = OP_RED_P;
         3'd3:    seed_op = OP_RED_Q;
         default: seed_op = OP_RED_A0;
      endcase
   end

   // accumulate first so the products read the old base
   always_comb begin
      unique case (step_ff)
         STEP_ACC0: bit_op = OP_ACC0;
         STEP_ACC1: bit_op = OP_ACC1;
         STEP_SQ00: bit_op = OP_SQ00;
         STEP_SQ01: bit_op = OP_SQ01;
         STEP_SQ10: bit_op = OP_SQ10;
         STEP_SQ11: bit_op = OP_SQ11;
         default:   bit_op = OP_SQ11;
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      exp_in     = exp_ff;
      cmd.load   = 1'b0;
      cmd.k_zero = k_zero;
      cmd.issue  = 1'b0;
      cmd.op     = seed_op;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               exp_in   = k_zero ? '0 : idx_k - INDEX_BITS'(1);
               step_in  = '0;
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            cmd.issue = 1'b1;
            if (step_ff == STEP_SEED_LAST) begin
               step_in  = '0;
               state_in = ST_SEED_WAIT;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_SEED_WAIT: begin
            if (!status.pipe_busy) begin
               state_in = (exp_ff == '0) ? ST_FIN : ST_BIT;
            end
         end
         ST_BIT: begin
            cmd.op = bit_op;
            if (step_ff == STEP_ACC0 || step_ff == STEP_ACC1) begin
               cmd.issue = exp_ff[0];
            end else begin
               cmd.issue = 1'b1;
            end
            if (step_ff == STEP_BIT_LAST) begin
               step_in  = '0;
               state_in = ST_BIT_WAIT;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_BIT_WAIT: begin
            if (!status.pipe_busy) begin
               exp_in   = exp_shift;
               state_in = (exp_shift == '0) ? ST_FIN : ST_BIT;
            end
         end
         ST_FIN: begin
            cmd.op = OP_FINAL;
            if (!status.rsp_busy) begin
               cmd.issue = 1'b1;
               state_in  = ST_FIN_WAIT;
            end
         end
         ST_FIN_WAIT: begin
            cmd.op = OP_FINAL;
            if (!status.pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         exp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         exp_ff   <= exp_in;
      end
   end

   // no request is taken while in reset
   assign req_stall = reset || (state_ff != ST_IDLE);

endmodule

// File: tb/sv/second_order_recurrence_mod_power_checker.sv
`timescale 1ns / 1ps
module second_order_recurrence_mod_power_checker
   import sorm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [VALUE_W-1:0] req_seed_first,
   input  logic [VALUE_W-1:0] req_seed_second,
   input  logic [VALUE_W-1:0] req_coef_p,
   input  logic [VALUE_W-1:0] req_coef_q,
   input  logic [INDEX_W-1:0] req_term_index,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [VALUE_W-1:0] rsp_term_value,
   output int                 mismatch_count,
   output int                 outstanding
);

   // 2x2 matrix, entries kept reduced
   typedef struct packed {
      logic [63:0] m00;
      logic [63:0] m01;
      logic [63:0] m10;
      logic [63:0] m11;
   } mat2_t;

   // one request and the term it should produce
   typedef struct packed {
      logic [VALUE_W-1:0] a0;
      logic [VALUE_W-1:0] a1;
      logic [VALUE_W-1:0] p;
      logic [VALUE_W-1:0] q;
      logic [INDEX_W-1:0] k;
      logic [VALUE_W-1:0] term;
   } term_request_t;

   term_request_t pending_terms[$];
   int            errors = 0;

   function automatic logic [63:0] mod_reduce(input logic [63:0] v);
      return v % 64'(MODULUS_DEF);
   endfunction

   function automatic mat2_t mat_product(input mat2_t x, input mat2_t y);
      mat2_t r;
      r.m00 = mod_reduce(mod_reduce(x.m00 * y.m00) + mod_reduce(x.m01 * y.m10));
      r.m01 = mod_reduce(mod_reduce(x.m00 * y.m01) + mod_reduce(x.m01 * y.m11));
      r.m10 = mod_reduce(mod_reduce(x.m10 * y.m00) + mod_reduce(x.m11 * y.m10));
      r.m11 = mod_reduce(mod_reduce(x.m10 * y.m01) + mod_reduce(x.m11 * y.m11));
      return r;
   endfunction

   // term k of a(n) = p*a(n-1) + q*a(n-2) by companion matrix power
   function automatic logic [VALUE_W-1:0] recurrence_term(
      input logic [VALUE_W-1:0] a0_in,
      input logic [VALUE_W-1:0] a1_in,
      input logic [VALUE_W-1:0] p_in,
      input logic [VALUE_W-1:0] q_in,
      input logic [INDEX_W-1:0] k_in
   );
      logic [63:0] a0;
      logic [63:0] a1;
      logic [63:0] k;
      logic [63:0] power;
      logic [63:0] value;
      mat2_t       base;
      mat2_t       acc;
      a0 = mod_reduce(64'(a0_in));
      a1 = mod_reduce(64'(a1_in));
      k  = 64'(k_in) & ((64'd1 << INDEX_BITS_DEF) - 64'd1);
      if (k == 64'd0) begin
         value = a0;
      end else if (k == 64'd1) begin
         value = a1;
      end else begin
         base.m00 = mod_reduce(64'(p_in));
         base.m01 = mod_reduce(64'(q_in));
         base.m10 = mod_reduce(64'd1);
         base.m11 = 64'd0;
         acc.m00  = mod_reduce(64'd1);
         acc.m01  = 64'd0;
         acc.m10  = 64'd0;
         acc.m11  = mod_reduce(64'd1);
         power    = k - 64'd1;
         // square and multiply over the index bits
         for (int b = 0; b < INDEX_BITS_DEF; b++) begin
            if (power[b]) acc = mat_product(acc, base);
            base = mat_product(base, base);
         end
         value = mod_reduce(mod_reduce(acc.m00 * a1) + mod_reduce(acc.m01 * a0));
      end
      return value[VALUE_W-1:0];
   endfunction

   always @(posedge clock) begin
      term_request_t want;
      if (!reset) begin
         // result transaction against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_terms.size() == 0) begin
               if (errors < 10)
                  $display("[%0t] unexpected result term_value=%0d", $time, rsp_term_value);
               errors++;
            end else begin
               want = pending_terms.pop_front();
               if (rsp_term_value !== want.term) begin
                  if (errors < 10)
                     $display("[%0t] term mismatch a0=%0d a1=%0d p=%0d q=%0d k=%0d: exp %0d got %0d",
                              $time, want.a0, want.a1, want.p, want.q, want.k,
                              want.term, rsp_term_value);
                  errors++;
               end
            end
         end
         // request transaction: predict its term
         if (req_valid && !req_stall) begin
            want.a0   = req_seed_first;
            want.a1   = req_seed_second;
            want.p    = req_coef_p;
            want.q    = req_coef_q;
            want.k    = req_term_index;
            want.term = recurrence_term(req_seed_first, req_seed_second, req_coef_p,
                                        req_coef_q, req_term_index);
            pending_terms.push_back(want);
         end
      end
      mismatch_count <= errors;
      outstanding    <= pending_terms.size();
   end

endmodule

// File: tb/sv/second_order_recurrence_mod_power_core_tb.sv
`timescale 1ns / 1ps
module second_order_recurrence_mod_power_core_tb;
   import sorm_pkg::*;

   localparam int HANG_LIMIT    = 4000;
   localparam int DRAIN_CYCLES  = 400;
   localparam int PHASE_ITEMS   = 275;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [VALUE_W-1:0] req_seed_first = '0;
   logic [VALUE_W-1:0] req_seed_second = '0;
   logic [VALUE_W-1:0] req_coef_p = '0;
   logic [VALUE_W-1:0] req_coef_q = '0;
   logic [INDEX_W-1:0] req_term_index = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [VALUE_W-1:0] rsp_term_value;

   int   mismatch_count;
   int   outstanding;
   int   quiet_cycles = 0;
   int   stall_left = 0;
   logic rsp_calm = 1'b1;
   logic req_calm = 1'b1;

   second_order_recurrence_mod_power_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_seed_first  (req_seed_first),
      .req_seed_second (req_seed_second),
      .req_coef_p      (req_coef_p),
      .req_coef_q      (req_coef_q),
      .req_term_index  (req_term_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_term_value  (rsp_term_value)
   );

   second_order_recurrence_mod_power_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_seed_first  (req_seed_first),
      .req_seed_second (req_seed_second),
      .req_coef_p      (req_coef_p),
      .req_coef_q      (req_coef_q),
      .req_term_index  (req_term_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_term_value  (rsp_term_value),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding)
   );

   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // operand: mostly in range, some edge values, some past the modulus
   function automatic logic [VALUE_W-1:0] rand_operand();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return VALUE_W'($urandom_range(0, 9999));
      if (r < 85) begin
         case ($urandom_range(0, 3))
            0: return VALUE_W'(0);
            1: return VALUE_W'(1);
            2: return VALUE_W'(9998);
            default: return VALUE_W'(9999);
         endcase
      end
      return VALUE_W'($urandom_range(0, 16383));
   endfunction

   // index: many short ones keep the run fast, some use every bit
   function automatic logic [INDEX_W-1:0] rand_index();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return INDEX_W'($urandom_range(0, 3));
      if (r < 55) return INDEX_W'($urandom_range(0, 255));
      if (r < 80) return INDEX_W'($urandom_range(0, 65535));
      return INDEX_W'($urandom);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!rsp_calm && $urandom_range(0, 3) == 0) stall_left <= idle_length();
      end
   end

   // hang detection: cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request transaction, after an optional gap
   task automatic send_term_request(
      input logic [VALUE_W-1:0] a0,
      input logic [VALUE_W-1:0] a1,
      input logic [VALUE_W-1:0] p,
      input logic [VALUE_W-1:0] q,
      input logic [INDEX_W-1:0] k
   );
      int gap;
      gap = req_calm ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_seed_first  <= a0;
      req_seed_second <= a1;
      req_coef_p      <= p;
      req_coef_q      <= q;
      req_term_index  <= k;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off until every predicted term has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: index zero and one, wrapping operands, extreme indexes
      send_term_request(0, 0, 0, 0, 0);
      send_term_request(1234, 5678, 1, 1, 0);
      send_term_request(1234, 5678, 1, 1, 1);
      send_term_request(0, 1, 1, 1, 2);
      send_term_request(0, 1, 1, 1, 3);
      send_term_request(0, 1, 1, 1, 10);
      send_term_request(9999, 9999, 9999, 9999, 2);
      send_term_request(9999, 9999, 9999, 9999, 31'h7fffffff);
      send_term_request(16383, 16383, 16383, 16383, 0);
      send_term_request(16383, 16383, 16383, 16383, 1);
      send_term_request(16383, 16383, 16383, 16383, 31'h7fffffff);
      send_term_request(10000, 10000, 10000, 10000, 5);
      send_term_request(5, 7, 0, 0, 3);
      send_term_request(5, 7, 2, 3, 31'h40000000);
      send_term_request(1, 2, 3, 4, 31'h40000001);
      send_term_request(2, 1, 1, 1, 31'h7ffffffe);
      send_term_request(3, 4, 9999, 1, 1000000);
      wait_for_drain();

      // random phases, idling on all but one
      for (int phase = 0; phase < 4; phase++) begin
         req_calm = (phase == 2);
         rsp_calm <= (phase == 2);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_term_request(rand_operand(), rand_operand(), rand_operand(),
                              rand_operand(), rand_index());
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
